>>> rtl/core/avp_pkg.sv
// Shared types and constants of the altitude/velocity PID block.
// Used by avp_setpoint and altitude_velocity_pid; depends on nothing.
package avp_pkg;

    localparam int InDataWidth  = 112;
    localparam int InUserWidth  = 2;
    localparam int OutDataWidth = 32;
    localparam int CfgIdxWidth  = 2;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_ALT_P_GAIN = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_VEL_P_GAIN = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_VEL_I_GAIN = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_VEL_D_GAIN = 2'd3;

    localparam logic signed [11:0] TILT_LIMIT    = 12'sd800;
    localparam logic signed [21:0] ALT_ERR_LIMIT = 22'sd500;
    localparam logic signed [9:0]  ALT_DEADBAND  = 10'sd5;
    localparam logic signed [18:0] VEL_SET_LIMIT = 19'sd300;
    localparam logic signed [20:0] VEL_P_LIMIT   = 21'sd300;
    localparam logic signed [25:0] INTEG_LIMIT   = 26'sd2457600;
    localparam logic signed [15:0] ACC_D_LIMIT   = 16'sd150;

    // Request after setpoint stage.
    typedef struct packed {
        logic               tilted;
        logic               armed;
        logic signed [9:0]  setpoint;
        logic signed [15:0] vel;
        logic signed [20:0] held;
        logic signed [24:0] d_prod;
    } t_s1;

    // Request after velocity stage.
    typedef struct packed {
        logic               tilted;
        logic signed [24:0] p_prod;
        logic signed [24:0] d_prod;
        logic signed [20:0] held;
    } t_s2;

endpackage

>>> rtl/core/avp_setpoint.sv
// Outer altitude loop: clamped error, deadband, P gain, setpoint clamp; in velocity mode the stick passes through.
// Combinational; uses avp_pkg constants.
module avp_setpoint (
    input  logic signed [20:0] i_hold,
    input  logic signed [20:0] i_est,
    input  logic               i_vmode,
    input  logic signed [9:0]  i_stick,
    input  logic [7:0]         i_gain,
    output logic signed [9:0]  o_setpoint
);
    import avp_pkg::*;

    logic signed [21:0] diff;
    logic signed [9:0]  err;
    logic signed [9:0]  err_db;
    logic signed [18:0] prod;
    logic signed [18:0] quot;
    logic signed [9:0]  alt_sp;

    always_comb begin
        diff = {i_hold[20], i_hold} - {i_est[20], i_est};
        if (diff > ALT_ERR_LIMIT) begin
            err = ALT_ERR_LIMIT[9:0];
        end else if (diff < -ALT_ERR_LIMIT) begin
            err = -ALT_ERR_LIMIT[9:0];
        end else begin
            err = diff[9:0];
        end

        if (err > ALT_DEADBAND) begin
            err_db = err - ALT_DEADBAND;
        end else if (err < -ALT_DEADBAND) begin
            err_db = err + ALT_DEADBAND;
        end else begin
            err_db = '0;
        end

        prod = $signed({1'b0, i_gain}) * err_db;
        // truncate toward zero: bias negatives before the shift
        quot = (prod + (prod[18] ? 19'sd127 : 19'sd0)) >>> 7;

        if (quot > VEL_SET_LIMIT) begin
            alt_sp = VEL_SET_LIMIT[9:0];
        end else if (quot < -VEL_SET_LIMIT) begin
            alt_sp = -VEL_SET_LIMIT[9:0];
        end else begin
            alt_sp = quot[9:0];
        end

        o_setpoint = i_vmode ? i_stick : alt_sp;
    end

endmodule

>>> rtl/core/altitude_velocity_pid.sv
// Cascaded altitude / vertical velocity PID controller, top level.
// Throughput one request per cycle while m_axis_tready allows; a request passes through r_s1, r_s2 and r_out to m_axis.
// Three registered stages (setpoint, velocity loop with integrator, sum) with per-stage ready.
// Synchronous active-low reset clears gains, held altitude, integrator, previous
// acceleration and all stage valid flags. Depends on avp_pkg and avp_setpoint.
module altitude_velocity_pid (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // est_altitude[20:0], vertical_velocity[36:21], accel_z[52:37], roll_tilt[64:53],
    // pitch_tilt[76:65], armed[77], stick_velocity[87:78], hold_value[108:88], zero
    input  logic [avp_pkg::InDataWidth-1:0]      s_axis_tdata,
    // velocity_mode[0], hold_load[1]
    input  logic [avp_pkg::InUserWidth-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // throttle_adjust[10:0], held_altitude[31:11]
    output logic [avp_pkg::OutDataWidth-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [avp_pkg::CfgIdxWidth-1:0]      i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);
    import avp_pkg::*;

    // gains
    logic [7:0] r_alt_p, r_vel_p, r_vel_i, r_vel_d;

    // state
    logic signed [20:0] r_hold, n_hold;
    logic signed [22:0] r_integ, n_integ;
    logic signed [15:0] r_prev;

    // stages
    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    logic [OutDataWidth-1:0] r_out, n_out;

    logic rdy1, rdy2, rdy3, in_fire;

    // input fields
    logic signed [20:0] est, hval;
    logic signed [15:0] vel, acc;
    logic signed [11:0] roll, pitch;
    logic signed [9:0]  stick;
    logic               armed, vmode, load;

    logic               tilt_ok;
    logic signed [20:0] hold_cur;
    logic signed [9:0]  setpoint;
    logic signed [16:0] acc_sum;
    logic signed [25:0] d_full;

    assign est   = s_axis_tdata[20:0];
    assign vel   = s_axis_tdata[36:21];
    assign acc   = s_axis_tdata[52:37];
    assign roll  = s_axis_tdata[64:53];
    assign pitch = s_axis_tdata[76:65];
    assign armed = s_axis_tdata[77];
    assign stick = s_axis_tdata[87:78];
    assign hval  = s_axis_tdata[108:88];
    assign vmode = s_axis_tuser[0];
    assign load  = s_axis_tuser[1];

    assign rdy3          = !r_v3 || m_axis_tready;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;
    assign in_fire       = s_axis_tvalid && rdy1;
    assign o_cfg_ready   = 1'b1;

    // ---- stage 0: hold update, setpoint, D product
    always_comb begin
        tilt_ok  = (roll < TILT_LIMIT) && (roll > -TILT_LIMIT)
                && (pitch < TILT_LIMIT) && (pitch > -TILT_LIMIT);
        hold_cur = load ? hval : r_hold;
        n_hold   = (tilt_ok && !armed) ? est : hold_cur;
        acc_sum  = {acc[15], acc} + {r_prev[15], r_prev};
        d_full   = $signed({1'b0, r_vel_d}) * acc_sum;

        n_s1.tilted   = !tilt_ok;
        n_s1.armed    = armed;
        n_s1.setpoint = setpoint;
        n_s1.vel      = vel;
        n_s1.held     = n_hold;
        n_s1.d_prod   = d_full[24:0];
    end

    avp_setpoint u_setpoint (
        .i_hold     (n_hold),
        .i_est      (est),
        .i_vmode    (vmode),
        .i_stick    (stick),
        .i_gain     (r_alt_p),
        .o_setpoint (setpoint)
    );

    // ---- stage 1: velocity error, P product, integrator
    logic signed [16:0] ve;
    logic signed [25:0] p_full, i_full, integ_sum;
    logic signed [22:0] integ_clamped;

    always_comb begin
        ve        = {{7{r_s1.setpoint[9]}}, r_s1.setpoint} - {r_s1.vel[15], r_s1.vel};
        p_full    = $signed({1'b0, r_vel_p}) * ve;
        i_full    = $signed({1'b0, r_vel_i}) * ve;
        integ_sum = {{3{r_integ[22]}}, r_integ} + i_full;
        if (integ_sum > INTEG_LIMIT) begin
            integ_clamped = INTEG_LIMIT[22:0];
        end else if (integ_sum < -INTEG_LIMIT) begin
            integ_clamped = -INTEG_LIMIT[22:0];
        end else begin
            integ_clamped = integ_sum[22:0];
        end

        if (r_s1.tilted) begin
            n_integ = r_integ;
        end else if (!r_s1.armed) begin
            n_integ = '0;
        end else begin
            n_integ = integ_clamped;
        end

        n_s2.tilted = r_s1.tilted;
        n_s2.p_prod = p_full[24:0];
        n_s2.d_prod = r_s1.d_prod;
        n_s2.held   = r_s1.held;
    end

    // ---- stage 2: scale, clamp and sum the three terms; result is zero when tilted
    logic signed [20:0] p_quot;
    logic signed [9:0]  p_term;
    logic signed [22:0] i_quot;
    logic signed [15:0] d_quot;
    logic signed [8:0]  d_term;
    logic signed [10:0] result;

    always_comb begin
        p_quot = 21'((r_s2.p_prod + (r_s2.p_prod[24] ? 25'sd31 : 25'sd0)) >>> 5);
        if (p_quot > VEL_P_LIMIT) begin
            p_term = VEL_P_LIMIT[9:0];
        end else if (p_quot < -VEL_P_LIMIT) begin
            p_term = -VEL_P_LIMIT[9:0];
        end else begin
            p_term = p_quot[9:0];
        end

        // r_integ holds this request's updated value until the next stage-2 load
        i_quot = (r_integ + (r_integ[22] ? 23'sd8191 : 23'sd0)) >>> 13;

        d_quot = 16'((r_s2.d_prod + (r_s2.d_prod[24] ? 25'sd511 : 25'sd0)) >>> 9);
        if (d_quot > ACC_D_LIMIT) begin
            d_term = ACC_D_LIMIT[8:0];
        end else if (d_quot < -ACC_D_LIMIT) begin
            d_term = -ACC_D_LIMIT[8:0];
        end else begin
            d_term = d_quot[8:0];
        end

        result = {p_term[9], p_term} + {i_quot[9], i_quot[9:0]}
               - {{2{d_term[8]}}, d_term};
        if (r_s2.tilted) begin
            result = '0;
        end
        n_out = {r_s2.held, result};
    end

    // ---- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_p <= '0;
            r_vel_p <= '0;
            r_vel_i <= '0;
            r_vel_d <= '0;
            r_hold  <= '0;
            r_integ <= '0;
            r_prev  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ALT_P_GAIN: r_alt_p <= i_cfg_data;
                    CFG_VEL_P_GAIN: r_vel_p <= i_cfg_data;
                    CFG_VEL_I_GAIN: r_vel_i <= i_cfg_data;
                    CFG_VEL_D_GAIN: r_vel_d <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_hold <= n_hold;
                r_prev <= acc;
            end
            if (r_v1 && rdy2) begin
                r_integ <= n_integ;
            end
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
        if (r_v1 && rdy2) begin
            r_s2 <= n_s2;
        end
        if (r_v2 && rdy3) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_out;

endmodule
